@@ sv/lpfi_pkg.sv @@
// Shared types and constants for the linear-probe find-or-insert hash table.
// No dependencies; every other file refers to this package by scoped names.
package lpfi_pkg;

    localparam int TAG_W       = 64;
    localparam int TAG_FLAG    = TAG_W - 1;   // occupied flag bit of a stored tag
    localparam int HASH_W      = 64;
    localparam int KEY_IN_W    = 64;
    localparam int SLOT_OUT_W  = 10;
    localparam int TOTAL_OUT_W = 11;
    localparam int STATUS_W    = 2;

    localparam logic OP_FIND_OR_INSERT = 1'b0;
    localparam logic OP_FIND_ONLY      = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_MATCHED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    // Outcome of comparing one slot against the item being probed.
    typedef struct packed {
        logic occupied;
        logic hit;
    } t_probe;

endpackage

@@ sv/lpfi_store.sv @@
// Slot store: tag memory and key memory, one write port and one registered read port each.
// Depends on lpfi_pkg.
module lpfi_store #(
    parameter int SLOTS    = 1024,
    parameter int KEY_BITS = 64,
    parameter int ADDR_W   = $clog2(SLOTS)
) (
    input  logic                      i_clk,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    input  logic                      i_tag_we,
    input  logic                      i_key_we,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [lpfi_pkg::TAG_W-1:0] i_wr_tag,
    input  logic [KEY_BITS-1:0]       i_wr_key,
    output logic [lpfi_pkg::TAG_W-1:0] o_rd_tag,
    output logic [KEY_BITS-1:0]       o_rd_key
);

    logic [lpfi_pkg::TAG_W-1:0] r_tag_mem [SLOTS];
    logic [KEY_BITS-1:0]        r_key_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_tag_we) begin
            r_tag_mem[i_wr_addr] <= i_wr_tag;
        end
        o_rd_tag <= r_tag_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        o_rd_key <= r_key_mem[i_rd_addr];
    end

endmodule

@@ sv/lpfi_cmp.sv @@
// Slot compare unit: occupied flag, tag match with the flag bit ignored, key match.
// Depends on lpfi_pkg.
module lpfi_cmp #(
    parameter int KEY_BITS = 64
) (
    input  logic [lpfi_pkg::TAG_W-1:0]  i_tag,
    input  logic [KEY_BITS-1:0]         i_slot_key,
    input  logic [lpfi_pkg::HASH_W-1:0] i_hash,
    input  logic [KEY_BITS-1:0]         i_key,
    output lpfi_pkg::t_probe            o_probe
);

    logic tag_eq;

    assign tag_eq = (i_tag[lpfi_pkg::TAG_FLAG-1:0] == i_hash[lpfi_pkg::TAG_FLAG-1:0]);

    always_comb begin
        o_probe.occupied = i_tag[lpfi_pkg::TAG_FLAG];
        o_probe.hit      = i_tag[lpfi_pkg::TAG_FLAG] && tag_eq && (i_slot_key == i_key);
    end

endmodule

@@ sv/linear_probe_find_or_insert.sv @@
// Linear-probe find-or-insert hash table: sequencer, probe registers and result register.
// After reset a clearing pass empties the tag memory slot by slot, with input stalled.
// A result registers once P slots are probed, P being 1..SLOTS, plus any wait for a stalled
// earlier result to leave the output register. One slot per cycle, the last one held while
// that wait lasts; the next item is accepted the cycle after the result.
// Depends on lpfi_pkg, lpfi_store and lpfi_cmp.
module linear_probe_find_or_insert #(
    parameter int SLOTS    = 1024,
    parameter int KEY_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [lpfi_pkg::HASH_W-1:0]       i_hash_value,
    input  logic [lpfi_pkg::KEY_IN_W-1:0]     i_key_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lpfi_pkg::SLOT_OUT_W-1:0]   o_slot_index,
    output logic [lpfi_pkg::STATUS_W-1:0]     o_status,
    output logic [lpfi_pkg::TOTAL_OUT_W-1:0]  o_entry_total
);

    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_PROBE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [ADDR_W-1:0]  r_clr, n_clr;
    logic [ADDR_W-1:0]  r_slot, n_slot;
    logic [ADDR_W-1:0]  r_home, n_home;
    logic [ADDR_W-1:0]  r_visit, n_visit;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_find_only, n_find_only;
    logic [lpfi_pkg::HASH_W-1:0] r_hash, n_hash;
    logic [KEY_BITS-1:0]         r_key, n_key;

    logic                               r_out_valid, n_out_valid;
    logic [lpfi_pkg::SLOT_OUT_W-1:0]    r_out_slot, n_out_slot;
    logic [lpfi_pkg::STATUS_W-1:0]      r_out_status, n_out_status;
    logic [lpfi_pkg::TOTAL_OUT_W-1:0]   r_out_total, n_out_total;

    logic                        in_accept;
    logic                        out_free;
    logic                        tag_we;
    logic                        key_we;
    logic [ADDR_W-1:0]           wr_addr;
    logic [lpfi_pkg::TAG_W-1:0]  wr_tag;
    logic [lpfi_pkg::TAG_W-1:0]  rd_tag;
    logic [KEY_BITS-1:0]         rd_key;
    lpfi_pkg::t_probe            probe;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    lpfi_store #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS),
        .ADDR_W   (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (n_slot),
        .i_tag_we  (tag_we),
        .i_key_we  (key_we),
        .i_wr_addr (wr_addr),
        .i_wr_tag  (wr_tag),
        .i_wr_key  (r_key),
        .o_rd_tag  (rd_tag),
        .o_rd_key  (rd_key)
    );

    lpfi_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_tag      (rd_tag),
        .i_slot_key (rd_key),
        .i_hash     (r_hash),
        .i_key      (r_key),
        .o_probe    (probe)
    );

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_slot       = r_slot;
        n_home       = r_home;
        n_visit      = r_visit;
        n_count      = r_count;
        n_find_only  = r_find_only;
        n_hash       = r_hash;
        n_key        = r_key;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        n_out_total  = r_out_total;
        tag_we       = 1'b0;
        key_we       = 1'b0;
        wr_addr      = r_slot;
        wr_tag       = {1'b1, r_hash[lpfi_pkg::TAG_FLAG-1:0]};

        case (r_state)
            S_CLEAR: begin
                tag_we  = 1'b1;
                wr_addr = r_clr;
                wr_tag  = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_find_only = (i_opcode == lpfi_pkg::OP_FIND_ONLY);
                    n_hash      = i_hash_value;
                    n_key       = i_key_value[KEY_BITS-1:0];
                    n_slot      = i_hash_value[ADDR_W-1:0];
                    n_home      = i_hash_value[ADDR_W-1:0];
                    n_visit     = '0;
                    n_state     = S_PROBE;
                end
            end
            S_PROBE: begin
                if (probe.hit) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_slot   = lpfi_pkg::SLOT_OUT_W'(r_slot);
                        n_out_status = lpfi_pkg::STATUS_MATCHED;
                        n_out_total  = lpfi_pkg::TOTAL_OUT_W'(r_count);
                        n_state      = S_IDLE;
                    end
                end else if (!probe.occupied) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_slot  = lpfi_pkg::SLOT_OUT_W'(r_slot);
                        n_state     = S_IDLE;
                        if (r_find_only) begin
                            n_out_status = lpfi_pkg::STATUS_NOT_FOUND;
                            n_out_total  = lpfi_pkg::TOTAL_OUT_W'(r_count);
                        end else begin
                            tag_we       = 1'b1;
                            key_we       = 1'b1;
                            n_count      = r_count + 1'b1;
                            n_out_status = lpfi_pkg::STATUS_INSERTED;
                            n_out_total  = lpfi_pkg::TOTAL_OUT_W'(r_count + 1'b1);
                        end
                    end
                end else if (r_visit == LAST_SLOT) begin
                    // every slot seen without a match: report at the home slot
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_slot   = lpfi_pkg::SLOT_OUT_W'(r_home);
                        n_out_status = r_find_only ? lpfi_pkg::STATUS_NOT_FOUND
                                                   : lpfi_pkg::STATUS_FULL;
                        n_out_total  = lpfi_pkg::TOTAL_OUT_W'(r_count);
                        n_state      = S_IDLE;
                    end
                end else begin
                    // wraps at SLOTS since SLOTS is a power of two
                    n_slot  = r_slot + 1'b1;
                    n_visit = r_visit + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_home       <= n_home;
        r_visit      <= n_visit;
        r_find_only  <= n_find_only;
        r_hash       <= n_hash;
        r_key        <= n_key;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
        r_out_total  <= n_out_total;
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_index  = r_out_slot;
    assign o_status      = r_out_status;
    assign o_entry_total = r_out_total;

endmodule

@@ verif/lpfi_checker.sv @@
// Result checker for the linear-probe find-or-insert table: keeps its own copy of the slot
// store, predicts each result at input acceptance and compares in order at output acceptance.
// Depends on lpfi_pkg for widths, opcodes and status codes.
module lpfi_checker #(
    parameter int SLOTS    = 1024,
    parameter int KEY_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_opcode,
    input  logic [lpfi_pkg::HASH_W-1:0]       i_hash_value,
    input  logic [lpfi_pkg::KEY_IN_W-1:0]     i_key_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [lpfi_pkg::SLOT_OUT_W-1:0]   i_slot_index,
    input  logic [lpfi_pkg::STATUS_W-1:0]     i_status,
    input  logic [lpfi_pkg::TOTAL_OUT_W-1:0]  i_entry_total,
    output int                                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lpfi_pkg::KEY_IN_W-1:0] KEY_MASK =
        {lpfi_pkg::KEY_IN_W{1'b1}} >> (lpfi_pkg::KEY_IN_W - KEY_BITS);

    typedef struct packed {
        logic [lpfi_pkg::SLOT_OUT_W-1:0]  slot;
        logic [lpfi_pkg::STATUS_W-1:0]    status;
        logic [lpfi_pkg::TOTAL_OUT_W-1:0] total;
    } t_outcome;

    logic [lpfi_pkg::TAG_W-1:0]    slot_tag [SLOTS];
    logic [lpfi_pkg::KEY_IN_W-1:0] slot_key [SLOTS];
    int unsigned                   live_entries = 0;
    t_outcome                      outcome_q [$];
    int                            mismatch_n = 0;
    int                            waiting_n  = 0;

    // anything still queued at the end is a missing result
    assign o_fail_count = mismatch_n + waiting_n;

    function automatic t_outcome outcome(input int unsigned slot,
                                         input logic [lpfi_pkg::STATUS_W-1:0] st);
        t_outcome res;
        res.slot   = lpfi_pkg::SLOT_OUT_W'(slot);
        res.status = st;
        res.total  = lpfi_pkg::TOTAL_OUT_W'(live_entries);
        return res;
    endfunction

    // Walk the table from the home slot; updates the shadow store on an insert.
    function automatic t_outcome probe_table(input logic op,
                                             input logic [lpfi_pkg::HASH_W-1:0] hash,
                                             input logic [lpfi_pkg::KEY_IN_W-1:0] key_in);
        logic [lpfi_pkg::KEY_IN_W-1:0] key;
        int unsigned                   home;
        int unsigned                   slot;
        key  = key_in & KEY_MASK;
        home = int'(hash % SLOTS);
        slot = home;
        for (int n = 0; n < SLOTS; n++) begin
            if (slot_tag[slot][lpfi_pkg::TAG_FLAG]) begin
                // occupied flag is not part of the tag compare
                if (slot_tag[slot][lpfi_pkg::TAG_FLAG-1:0] == hash[lpfi_pkg::TAG_FLAG-1:0] &&
                    slot_key[slot] == key)
                    return outcome(slot, lpfi_pkg::STATUS_MATCHED);
            end else if (op == lpfi_pkg::OP_FIND_ONLY) begin
                return outcome(slot, lpfi_pkg::STATUS_NOT_FOUND);
            end else begin
                slot_tag[slot]                     = hash;
                slot_tag[slot][lpfi_pkg::TAG_FLAG] = 1'b1;
                slot_key[slot]                     = key;
                live_entries++;
                return outcome(slot, lpfi_pkg::STATUS_INSERTED);
            end
            slot = (slot == SLOTS - 1) ? 0 : slot + 1;
        end
        return outcome(home, (op == lpfi_pkg::OP_FIND_ONLY) ? lpfi_pkg::STATUS_NOT_FOUND
                                                            : lpfi_pkg::STATUS_FULL);
    endfunction

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_tag[s] = '0;
                slot_key[s] = '0;
            end
            live_entries = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                outcome_q.push_back(probe_table(i_opcode, i_hash_value, i_key_value));
                waiting_n++;
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_slot_index, i_status, i_entry_total};
                if (outcome_q.size() == 0) begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("unexpected result transaction: slot %0d status %0d total %0d",
                                 got.slot, got.status, got.total);
                end else begin
                    want = outcome_q.pop_front();
                    waiting_n--;
                    if (got.slot !== want.slot || got.status !== want.status ||
                        got.total !== want.total) begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                            $display("result mismatch: expected slot %0d status %0d total %0d, %s",
                                     want.slot, want.status, want.total,
                                     $sformatf("got slot %0d status %0d total %0d",
                                               got.slot, got.status, got.total));
                    end
                end
            end
        end
    end

endmodule

@@ verif/linear_probe_find_or_insert_tb.sv @@
// Top testbench for linear_probe_find_or_insert: clock, reset, stimulus, output stalls and
// the verdict. Results are checked by lpfi_checker; depends on lpfi_pkg and the block.
module linear_probe_find_or_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 1024;
    localparam int KEY_BITS   = 64;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    // clearing pass or one full probe plus stalls, several times over
    localparam int IDLE_LIMIT = 4 * SLOTS + 256;

    localparam logic [lpfi_pkg::HASH_W-1:0] ALL_ONES = '1;
    localparam logic [lpfi_pkg::HASH_W-1:0] HI_BIT   = 64'h8000_0000_0000_0000;
    localparam logic [lpfi_pkg::HASH_W-1:0] PAT_A    = 64'h5555_5555_5555_5555;
    localparam logic [lpfi_pkg::HASH_W-1:0] PAT_B    = 64'hAAAA_AAAA_AAAA_AAAA;

    logic                              clk;
    logic                              rst_n      = 1'b0;
    logic                              in_valid   = 1'b0;
    logic                              in_stall;
    logic                              opcode     = lpfi_pkg::OP_FIND_OR_INSERT;
    logic [lpfi_pkg::HASH_W-1:0]       hash_value = '0;
    logic [lpfi_pkg::KEY_IN_W-1:0]     key_value  = '0;
    logic                              out_valid;
    logic                              out_stall  = 1'b0;
    logic [lpfi_pkg::SLOT_OUT_W-1:0]   slot_index;
    logic [lpfi_pkg::STATUS_W-1:0]     status;
    logic [lpfi_pkg::TOTAL_OUT_W-1:0]  entry_total;

    int   fail_count;
    int   items_sent   = 0;
    int   results_seen = 0;
    int   idle_cycles  = 0;
    int   stall_left   = 0;
    logic calm         = 1'b0;

    // pairs known to be in the table; its size tracks the occupied count
    logic [lpfi_pkg::HASH_W-1:0]   pool_hash [$];
    logic [lpfi_pkg::KEY_IN_W-1:0] pool_key  [$];

    linear_probe_find_or_insert #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_hash_value  (hash_value),
        .i_key_value   (key_value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_slot_index  (slot_index),
        .o_status      (status),
        .o_entry_total (entry_total)
    );

    lpfi_checker #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) table_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_hash_value  (hash_value),
        .i_key_value   (key_value),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_slot_index  (slot_index),
        .i_status      (status),
        .i_entry_total (entry_total),
        .o_fail_count  (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // stretches with no idling on either side
    always @(posedge clk) begin
        if ($urandom_range(0, 63) == 0)
            calm <= ~calm;
    end

    // receiver: after each result transaction, may stall the next one; never in calm stretches
    always @(posedge clk) begin
        int hold;
        if (out_valid && !out_stall) begin
            hold = calm ? 0 : int'($urandom_range(0, 4));
            results_seen <= results_seen + 1;
            stall_left   <= hold;
            out_stall    <= (hold != 0);
        end else if (out_valid && stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // valid stays high between back-to-back transactions
    task automatic push_item(input logic op, input logic [lpfi_pkg::HASH_W-1:0] hash,
                             input logic [lpfi_pkg::KEY_IN_W-1:0] key);
        int gap;
        gap = calm ? 0 : int'($urandom_range(0, 4));
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        hash_value <= hash;
        key_value  <= key;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic add_fresh(input logic [lpfi_pkg::HASH_W-1:0] hash,
                             input logic [lpfi_pkg::KEY_IN_W-1:0] key);
        push_item(lpfi_pkg::OP_FIND_OR_INSERT, hash, key);
        if (pool_hash.size() < SLOTS) begin
            pool_hash.push_back(hash);
            pool_key.push_back(key);
        end
    endtask

    task automatic random_item(input int insert_pct);
        int                            r;
        int                            pick;
        logic [lpfi_pkg::HASH_W-1:0]   hash;
        logic [lpfi_pkg::KEY_IN_W-1:0] key;
        r    = $urandom_range(0, 99);
        pick = $urandom_range(0, pool_hash.size() - 1);
        hash = pool_hash[pick];
        hash[lpfi_pkg::TAG_FLAG] = 1'($urandom_range(0, 1));
        if (r < insert_pct) begin
            case ($urandom_range(0, 3))
                0: begin
                    // same home slot, different tag
                    hash = rand64();
                    hash[SLOT_BITS-1:0] = pool_hash[pick][SLOT_BITS-1:0];
                end
                1: ;                 // same tag, new key
                default: hash = rand64();
            endcase
            add_fresh(hash, rand64());
        end else if (r < insert_pct + 35) begin
            push_item(($urandom_range(0, 1) != 0) ? lpfi_pkg::OP_FIND_ONLY
                                                  : lpfi_pkg::OP_FIND_OR_INSERT,
                      hash, pool_key[pick]);
        end else if (r < insert_pct + 45) begin
            key = pool_key[pick] ^ (64'd1 << $urandom_range(0, 63));
            push_item(lpfi_pkg::OP_FIND_ONLY, pool_hash[pick], key);
        end else begin
            push_item(lpfi_pkg::OP_FIND_ONLY, rand64(), rand64());
        end
    endtask

    initial begin
        logic [lpfi_pkg::HASH_W-1:0]   wrap_hash;
        logic [lpfi_pkg::KEY_IN_W-1:0] wrap_key;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty slot, hit, top-bit-only difference, key collision, wraparound
        push_item(lpfi_pkg::OP_FIND_ONLY, '0, '0);
        add_fresh('0, '0);
        push_item(lpfi_pkg::OP_FIND_OR_INSERT, '0, '0);
        push_item(lpfi_pkg::OP_FIND_ONLY, HI_BIT, '0);
        add_fresh('0, ALL_ONES);
        push_item(lpfi_pkg::OP_FIND_ONLY, '0, ALL_ONES);
        add_fresh(ALL_ONES, ALL_ONES);
        add_fresh(ALL_ONES ^ HI_BIT, '0);
        push_item(lpfi_pkg::OP_FIND_ONLY, ALL_ONES, '0);
        push_item(lpfi_pkg::OP_FIND_ONLY, 64'h3FF, ALL_ONES);
        add_fresh(PAT_A, PAT_B);
        add_fresh(PAT_B, PAT_A);
        push_item(lpfi_pkg::OP_FIND_ONLY, PAT_A | HI_BIT, PAT_B);
        push_item(lpfi_pkg::OP_FIND_OR_INSERT, PAT_B, PAT_A);
        push_item(lpfi_pkg::OP_FIND_ONLY, rand64(), rand64());
        wrap_hash = rand64();
        wrap_hash[SLOT_BITS-1:0] = SLOT_BITS'(SLOTS - 2);
        add_fresh(wrap_hash, rand64());
        wrap_hash ^= 64'd1 << 40;
        wrap_key  = rand64();
        add_fresh(wrap_hash, wrap_key);
        push_item(lpfi_pkg::OP_FIND_ONLY, wrap_hash, wrap_key);
        push_item(lpfi_pkg::OP_FIND_OR_INSERT, ALL_ONES ^ HI_BIT, ALL_ONES);

        repeat (150) random_item(40);
        // drive the table to full, then probe it with every kind of item
        while (pool_hash.size() < SLOTS) random_item(90);
        repeat (80) random_item(30);
        in_valid <= 1'b0;

        while (results_seen != items_sent) @(posedge clk);
        repeat (SLOTS + 16) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/lpfi_pkg.sv
sv/lpfi_store.sv
sv/lpfi_cmp.sv
sv/linear_probe_find_or_insert.sv
verif/lpfi_checker.sv
verif/linear_probe_find_or_insert_tb.sv
